### rtl/rlcd_pkg.sv
`default_nettype none

package rlcd_pkg;

    localparam int COLOUR_W     = 24;
    localparam int BITS_PER_LED = 24;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [7:0]  RST_ZERO_HIGH = 8'd7;
    localparam logic [7:0]  RST_ONE_HIGH  = 8'd18;
    localparam logic [7:0]  RST_PERIOD    = 8'd25;
    localparam logic [15:0] RST_LATCH     = 16'd20000;
    localparam logic [6:0]  RST_LEDS      = 7'd64;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_SET  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_HIGH = 3'd0,
        CFG_ONE_HIGH  = 3'd1,
        CFG_PERIOD    = 3'd2,
        CFG_LATCH     = 3'd3,
        CFG_LEDS      = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_SEND  = 3'b010,
        PH_LATCH = 3'b100
    } t_phase;

    typedef struct packed {
        logic       func;
        logic [7:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_item;

    typedef struct packed {
        logic line_level;
        logic frame_busy;
    } t_out_item;

endpackage

`default_nettype wire

### rtl/rlcd_store.sv
`default_nettype none

module rlcd_store #(
    parameter int MAX_LEDS = 64,
    parameter int AW       = 6
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_wr_en,
    input  wire  [AW-1:0]                    i_wr_addr,
    input  wire  [rlcd_pkg::COLOUR_W-1:0]    i_wr_data,
    input  wire  [AW-1:0]                    i_rd_addr,
    output logic [rlcd_pkg::COLOUR_W-1:0]    o_rd_data
);

    logic [rlcd_pkg::COLOUR_W-1:0] r_mem [0:MAX_LEDS-1];
    logic [MAX_LEDS-1:0]           r_valid;
    logic [rlcd_pkg::COLOUR_W-1:0] r_rd;
    logic                          r_rd_vld;
    logic                          rd_in_range;
    logic                          wr_hit;

    assign rd_in_range = ({1'b0, i_rd_addr} < (AW+1)'(MAX_LEDS));
    assign wr_hit      = i_wr_en && (i_wr_addr == i_rd_addr);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // write-first: a beat written this cycle is seen by the read
        if (wr_hit) begin
            r_rd <= i_wr_data;
        end else if (rd_in_range) begin
            r_rd <= r_mem[i_rd_addr];
        end else begin
            r_rd <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= wr_hit || (rd_in_range && r_valid[i_rd_addr]);
        end
    end

    // entries never written read as zero
    assign o_rd_data = r_rd_vld ? r_rd : '0;

endmodule

`default_nettype wire

### rtl/rgb_led_chain_driver.sv
// A result is registered when its item is accepted.
// Throughput: one item per cycle; the result register frees itself in the
// cycle it is taken, so input ready only drops while a result is stalled.
// The colour store is read ahead through its registered port.
// Reset: synchronous, active low; control and config registers return to
// defaults, the store reads as zero through per-entry valid bits, with no clearing pass.
`default_nettype none

module rgb_led_chain_driver #(
    parameter int MAX_LEDS = 64
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire  rlcd_pkg::t_in_item              i_in,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output rlcd_pkg::t_out_item                   o_out,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [rlcd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [rlcd_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int UW = 9;

    logic [7:0]  r_zero_high;
    logic [7:0]  r_one_high;
    logic [7:0]  r_period;
    logic [15:0] r_latch;
    logic [6:0]  r_leds;

    rlcd_pkg::t_phase r_phase, n_phase;
    logic             r_pending, n_pending;
    logic [AW-1:0]    r_led, n_led;
    logic [4:0]       r_bit, n_bit;
    logic [15:0]      r_tick, n_tick;
    logic [rlcd_pkg::COLOUR_W-1:0] r_shift, n_shift;
    logic             r_line, n_line;

    rlcd_pkg::t_out_item r_out;
    logic                r_out_valid;

    logic                          in_acc;
    logic                          wr_en;
    logic [AW-1:0]                 rd_addr;
    logic [rlcd_pkg::COLOUR_W-1:0] rd_colour;
    logic [rlcd_pkg::COLOUR_W-1:0] wr_colour;
    logic [UW-1:0]                 used;
    logic                          busy;
    logic [7:0]                    high;
    logic [16:0]                   tick1;
    logic [4:0]                    bit1;
    logic [UW-1:0]                 led1;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign used = ({2'b00, r_leds} > UW'(MAX_LEDS)) ? UW'(MAX_LEDS) : {2'b00, r_leds};
    assign wr_colour = {i_in.green, i_in.red, i_in.blue};

    // prefetch the colour that the next load will need
    assign rd_addr = (n_phase == rlcd_pkg::PH_SEND) ? (n_led + AW'(1)) : '0;

    rlcd_store #(
        .MAX_LEDS (MAX_LEDS),
        .AW       (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_in.led_index[AW-1:0]),
        .i_wr_data (wr_colour),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_colour)
    );

    always_comb begin
        n_phase   = r_phase;
        n_pending = r_pending;
        n_led     = r_led;
        n_bit     = r_bit;
        n_tick    = r_tick;
        n_shift   = r_shift;
        n_line    = r_line;
        wr_en     = 1'b0;
        busy      = (r_phase != rlcd_pkg::PH_IDLE);
        high      = '0;
        tick1     = '0;
        bit1      = '0;
        led1      = '0;
        if (in_acc) begin
            if (i_in.func == rlcd_pkg::FUNC_SET) begin
                if ({1'b0, i_in.led_index} < used) begin
                    wr_en     = 1'b1;
                    n_pending = 1'b1;
                end
            end else begin
                if (r_phase == rlcd_pkg::PH_IDLE && r_pending) begin
                    n_pending = 1'b0;
                    n_led     = '0;
                    n_bit     = '0;
                    n_tick    = '0;
                    if (used == '0) begin
                        n_phase = rlcd_pkg::PH_LATCH;
                    end else begin
                        n_phase = rlcd_pkg::PH_SEND;
                        n_shift = rd_colour;
                    end
                end
                busy = (n_phase != rlcd_pkg::PH_IDLE);
                unique case (n_phase)
                    rlcd_pkg::PH_SEND: begin
                        high   = n_shift[rlcd_pkg::COLOUR_W-1] ? r_one_high : r_zero_high;
                        n_line = ({8'b0, high} > n_tick);
                        tick1  = {1'b0, n_tick} + 17'd1;
                        if (tick1 >= {9'b0, r_period}) begin
                            n_tick  = '0;
                            n_shift = {n_shift[rlcd_pkg::COLOUR_W-2:0], 1'b0};
                            bit1    = n_bit + 5'd1;
                            n_bit   = bit1;
                            if (bit1 >= 5'(rlcd_pkg::BITS_PER_LED)) begin
                                led1 = UW'(n_led) + UW'(1);
                                if (led1 >= used) begin
                                    n_phase = rlcd_pkg::PH_LATCH;
                                    n_bit   = '0;
                                    n_led   = '0;
                                end else begin
                                    n_led   = led1[AW-1:0];
                                    n_shift = rd_colour;
                                    n_bit   = '0;
                                end
                            end
                        end else begin
                            n_tick = tick1[15:0];
                        end
                    end
                    rlcd_pkg::PH_LATCH: begin
                        n_line = 1'b0;
                        tick1  = {1'b0, n_tick} + 17'd1;
                        if (tick1 >= {1'b0, r_latch}) begin
                            n_phase = rlcd_pkg::PH_IDLE;
                            n_tick  = '0;
                        end else begin
                            n_tick = tick1[15:0];
                        end
                    end
                    default: begin
                        n_line = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_high <= rlcd_pkg::RST_ZERO_HIGH;
            r_one_high  <= rlcd_pkg::RST_ONE_HIGH;
            r_period    <= rlcd_pkg::RST_PERIOD;
            r_latch     <= rlcd_pkg::RST_LATCH;
            r_leds      <= rlcd_pkg::RST_LEDS;
        end else if (i_cfg_valid) begin
            unique case (rlcd_pkg::t_cfg_idx'(i_cfg_index))
                rlcd_pkg::CFG_ZERO_HIGH: r_zero_high <= i_cfg_data[7:0];
                rlcd_pkg::CFG_ONE_HIGH:  r_one_high  <= i_cfg_data[7:0];
                rlcd_pkg::CFG_PERIOD:    r_period    <= i_cfg_data[7:0];
                rlcd_pkg::CFG_LATCH:     r_latch     <= i_cfg_data;
                rlcd_pkg::CFG_LEDS:      r_leds      <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= rlcd_pkg::PH_IDLE;
            r_pending   <= 1'b0;
            r_led       <= '0;
            r_bit       <= '0;
            r_tick      <= '0;
            r_shift     <= '0;
            r_line      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_led     <= n_led;
            r_bit     <= n_bit;
            r_tick    <= n_tick;
            r_shift   <= n_shift;
            r_line    <= n_line;
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out.line_level <= n_line;
            r_out.frame_busy <= busy;
        end
    end

    a_bit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit < 5'(rlcd_pkg::BITS_PER_LED))
        else $error("bit pointer out of range");

    a_idle_tick_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == rlcd_pkg::PH_IDLE) |-> (r_tick == '0))
        else $error("tick counter not cleared in idle");

    a_idle_line_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.func == rlcd_pkg::FUNC_TICK && r_phase == rlcd_pkg::PH_IDLE
            && !r_pending) |=> (!r_line && !r_out.frame_busy))
        else $error("line driven while idle");

    a_accept_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_out_valid)
        else $error("accepted beat produced no result");

endmodule

`default_nettype wire
